// ===== src/ffha_pkg.sv =====
// shared types and constants for the first-fit heap allocator
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

    localparam int POOL_BYTES   = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int ADDR_W       = $clog2(POOL_BYTES);
    localparam int SIZE_W       = 13;
    localparam int LIVE_W       = 10;
    localparam int POS_W        = SIZE_W + 1;
    localparam int SUM_W        = SIZE_W + 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 2'd1;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] req_bytes;
        logic [31:0]       free_address;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [31:0]       block_address;
        logic [SIZE_W-1:0] bytes_in_use;
        logic [LIVE_W-1:0] blocks_in_use;
    } t_rsp;

    typedef struct packed {
        logic              in_use;
        logic [SIZE_W-1:0] size;
    } t_hdr;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_WALK,
        ST_EXAM,
        ST_FREE,
        ST_FREE_UPD
    } t_state;

endpackage

`default_nettype wire

// ===== src/first_fit_heap_allocator_top.sv =====
// first-fit heap allocator: header memory, chain walker and usage counters
// Usage: a request is taken at a rising edge with start high and busy low.
// i_req.func selects allocate or free. Each request gives exactly one result:
// o_done is high for one cycle with o_rsp valid, and the receiver must take it
// then; there is no back-pressure on the result side.
// Configuration (pool_base index 0, pool_size index 1) is written through the
// i_cfg_valid / o_cfg_ready channel; o_cfg_ready is always high.
// Timing: one request at a time. An allocate that fails the capacity check
// returns straight from the check; otherwise the walk visits each header with
// one memory read and one examine, and ends when a header is taken or breaks
// the chain, or when the walk reaches the pool end. A free returns after the
// address check (address outside the pool) or after a header read and update.
// The walk length, set by the one-read-per-cycle header memory, bounds rate.
// Reset: synchronous, active low. After reset the block sweeps the 4096-entry
// header memory to zero, one entry a cycle, holding busy high throughout the
// sweep; configuration writes are taken during the sweep.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ffha_pkg::t_req                      i_req,
    output logic                                o_done,
    output ffha_pkg::t_rsp                      o_rsp,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ffha_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ffha_pkg::*;

    localparam logic [SIZE_W-1:0] POOL_C = SIZE_W'(POOL_BYTES);
    localparam logic [SIZE_W-1:0] HDR_C  = SIZE_W'(HEADER_BYTES);

    t_state            r_state, n_state;
    logic [31:0]       r_pool_base;
    logic [SIZE_W-1:0] r_pool_size;
    t_req              r_req;
    logic [SIZE_W-1:0] r_used, n_used;
    logic [LIVE_W-1:0] r_live, n_live;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [ADDR_W-1:0] r_clr_addr;

    t_hdr              r_hdr_mem [POOL_BYTES];
    t_hdr              r_rd_data;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    t_hdr              mem_wdata;
    logic              finish;
    t_rsp              n_rsp;

    logic [SIZE_W-1:0] cap;
    logic [POS_W-1:0]  need;
    logic [SUM_W-1:0]  taken;
    logic              cap_fail, walk_end, pos_off;
    logic              hdr_new, hdr_reuse, hdr_broken;
    logic [31:0]       free_off, alloc_addr;
    logic              free_in_pool;
    logic [SIZE_W-1:0] free_payload;

    // request decode and header checks
    assign cap   = (r_pool_size > POOL_C) ? POOL_C : r_pool_size;
    assign need  = POS_W'(r_req.req_bytes) + POS_W'(HEADER_BYTES);
    assign taken = SUM_W'(r_used) + SUM_W'(r_live) * SUM_W'(HEADER_BYTES);
    assign cap_fail = (taken + SUM_W'(need)) > SUM_W'(cap);
    assign walk_end = (SUM_W'(r_pos) + SUM_W'(need)) >= SUM_W'(cap);
    assign pos_off  = r_pos >= POS_W'(POOL_BYTES);

    assign hdr_new    = !r_rd_data.in_use && (r_rd_data.size == '0);
    assign hdr_reuse  = !r_rd_data.in_use && (POS_W'(r_rd_data.size) > need);
    assign hdr_broken = r_rd_data.in_use && (r_rd_data.size == '0);

    assign free_off     = r_req.free_address - r_pool_base - 32'(HEADER_BYTES);
    assign free_in_pool = free_off < 32'(POOL_BYTES);
    assign free_payload = (r_rd_data.size > HDR_C) ? (r_rd_data.size - HDR_C) : '0;
    assign alloc_addr   = r_pool_base + 32'(r_pos) + 32'(HEADER_BYTES);

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(POOL_BYTES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) n_state = (i_req.func == FUNC_FREE) ? ST_FREE : ST_ALLOC;
            end
            ST_ALLOC: begin
                n_state = cap_fail ? ST_IDLE : ST_WALK;
            end
            ST_WALK: begin
                n_state = (walk_end || pos_off) ? ST_IDLE : ST_EXAM;
            end
            ST_EXAM: begin
                n_state = (hdr_new || hdr_reuse || hdr_broken) ? ST_IDLE : ST_WALK;
            end
            ST_FREE: begin
                n_state = free_in_pool ? ST_FREE_UPD : ST_IDLE;
            end
            ST_FREE_UPD: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // memory control, counters and result
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = r_clr_addr;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = r_pos[ADDR_W-1:0];
        finish     = 1'b0;
        n_rsp      = '0;
        n_rsp.ok   = 1'b1;
        n_used     = r_used;
        n_live     = r_live;
        n_pos      = r_pos;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_ALLOC: begin
                n_pos = '0;
                if (cap_fail) begin
                    finish   = 1'b1;
                    n_rsp.ok = 1'b0;
                end
            end
            ST_WALK: begin
                if (walk_end || pos_off) begin
                    finish   = 1'b1;
                    n_rsp.ok = 1'b0;
                end else begin
                    mem_re = 1'b1;
                end
            end
            ST_EXAM: begin
                mem_waddr = r_pos[ADDR_W-1:0];
                if (hdr_new) begin
                    mem_we              = 1'b1;
                    mem_wdata.in_use    = 1'b1;
                    mem_wdata.size      = need[SIZE_W-1:0];
                    n_live              = r_live + LIVE_W'(1);
                    n_used              = r_used + r_req.req_bytes;
                    finish              = 1'b1;
                    n_rsp.block_address = alloc_addr;
                end else if (hdr_reuse) begin
                    // reused whole, no split
                    mem_we              = 1'b1;
                    mem_wdata.in_use    = 1'b1;
                    mem_wdata.size      = r_rd_data.size;
                    n_live              = r_live + LIVE_W'(1);
                    n_used              = r_used + (r_rd_data.size - HDR_C);
                    finish              = 1'b1;
                    n_rsp.block_address = alloc_addr;
                end else if (hdr_broken) begin
                    finish   = 1'b1;
                    n_rsp.ok = 1'b0;
                end else begin
                    n_pos = r_pos + POS_W'(r_rd_data.size);
                end
            end
            ST_FREE: begin
                mem_raddr = free_off[ADDR_W-1:0];
                if (free_in_pool) begin
                    mem_re = 1'b1;
                end else begin
                    finish = 1'b1;
                end
            end
            ST_FREE_UPD: begin
                mem_we           = 1'b1;
                mem_waddr        = free_off[ADDR_W-1:0];
                mem_wdata.in_use = 1'b0;
                mem_wdata.size   = r_rd_data.size;
                n_live           = (r_live == '0) ? '0 : (r_live - LIVE_W'(1));
                n_used           = (r_used > free_payload) ? (r_used - free_payload) : '0;
                finish           = 1'b1;
            end
            default: begin
            end
        endcase
        n_rsp.bytes_in_use  = n_used;
        n_rsp.blocks_in_use = n_live;
    end

    // header memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hdr_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_hdr_mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_pool_base <= '0;
            r_pool_size <= POOL_C;
            r_used      <= '0;
            r_live      <= '0;
            o_done      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_live  <= n_live;
            o_done  <= finish;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_POOL_BASE: r_pool_base <= i_cfg_data;
                    CFG_POOL_SIZE: r_pool_size <= i_cfg_data[SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
        r_pos <= n_pos;
        if (finish) begin
            o_rsp <= n_rsp;
        end
    end

endmodule

`default_nettype wire

// ===== src/ffha_chk.sv =====
// port-level checks for the first-fit heap allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ffha_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input ffha_pkg::t_req                      i_req,
    input logic                                o_done,
    input ffha_pkg::t_rsp                      o_rsp,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready,
    input logic [ffha_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input logic [ffha_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // an accepted request keeps the block occupied in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a request");

    // a result only closes work that was in progress
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result strobe without preceding work");

    // an idle cycle with no request cannot produce a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> !o_done)
        else $error("result strobe without a request");

    // failed allocations report a zero address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.ok) |-> (o_rsp.block_address == 32'd0))
        else $error("failed allocation with nonzero address");

endmodule

bind first_fit_heap_allocator_top ffha_chk u_ffha_chk (.*);

`default_nettype wire
